// ----- design/lcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

    // Grey value width and the full-scale value.
    localparam int unsigned PIX_W = 8;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    // (pixel - min) * 255 is below 2^16; doubled plus the range stays below 2^17.
    localparam int unsigned NUM_W = 17;
    // Twice the range is at most 510.
    localparam int unsigned DEN_W = 9;
    // Divisor aligned to the top quotient bit.
    localparam int unsigned DSH_W = DEN_W + PIX_W - 1;
    // Counts the eight quotient steps.
    localparam int unsigned STEP_W = 3;
    localparam logic [STEP_W-1:0] LAST_STEP = 3'd7;

    // One map pixel with the range measured before it.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
    } t_job;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic empty;
        t_job head;
    } t_q_status;

endpackage

`default_nettype wire

// ----- design/linear_contrast_stretch.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: measure pixels transfer one per cycle while the queue is not full; the back end
//   takes one map pixel at a time (pop, eight restoring-division steps, hand-off) and
//   skips the division steps when it bypasses the divider. A map pixel shows on o_valid
//   after its hand-off, plus any time it waits in the queue behind earlier map pixels.
// Reset (synchronous, active low): min 255, max 0, queue empty, no result valid.

module linear_contrast_stretch #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_kind,
    input  wire logic [lcs_pkg::PIX_W-1:0] i_pixel,
    input  wire logic                      i_last,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [lcs_pkg::PIX_W-1:0]      o_out_pixel
);

    // The front end tracks the running minimum and maximum and turns every map
    // pixel into a job that carries the range seen so far. A last flag on a map
    // pixel clears the range after that pixel's job has been built.
    // The queue lets measure pixels keep streaming while the divider is busy;
    // the input stalls only when the queue is full.
    // The back end computes (2 * (p - min) * 255 + range) / (2 * range), which
    // is the rounded-half-up stretch, with one quotient bit per cycle. Pixels at
    // or outside the range and empty or flat ranges skip the divider. A result
    // register at the output lets the back end finish its next job while a
    // transfer is still stalled downstream.

    logic               q_full;
    logic               push;
    logic               pop;
    lcs_pkg::t_job      job;
    lcs_pkg::t_q_status q_status;

    lcs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .i_pixel  (i_pixel),
        .i_last   (i_last),
        .i_q_full (q_full),
        .o_stall  (o_stall),
        .o_push   (push),
        .o_job    (job)
    );

    lcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_status (q_status)
    );

    lcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (q_status),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_pixel (o_out_pixel)
    );

endmodule

`default_nettype wire

// ----- design/lcs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcs_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic                      i_kind,
    input  wire logic [lcs_pkg::PIX_W-1:0] i_pixel,
    input  wire logic                      i_last,
    input  wire logic                      i_q_full,
    output logic                           o_stall,
    output logic                           o_push,
    output lcs_pkg::t_job                  o_job
);

    logic [lcs_pkg::PIX_W-1:0] r_min;
    logic [lcs_pkg::PIX_W-1:0] r_max;
    logic                      accept;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept && i_kind;

    // The job carries the range as it stands before a last flag clears it.
    assign o_job.pixel = i_pixel;
    assign o_job.lo    = r_min;
    assign o_job.hi    = r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= lcs_pkg::PIX_MAX;
            r_max <= lcs_pkg::PIX_MIN;
        end else if (accept) begin
            if (!i_kind) begin
                if (i_pixel < r_min) begin
                    r_min <= i_pixel;
                end
                if (i_pixel > r_max) begin
                    r_max <= i_pixel;
                end
            end else if (i_last) begin
                r_min <= lcs_pkg::PIX_MAX;
                r_max <= lcs_pkg::PIX_MIN;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/lcs_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcs_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lcs_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output lcs_pkg::t_q_status o_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lcs_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full          = (r_count == CNT_FULL);
    assign o_status.empty  = (r_count == '0);
    assign o_status.head   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue read while empty");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- design/lcs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcs_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire lcs_pkg::t_q_status        i_status,
    output logic                           o_pop,
    input  wire logic                      i_stall,
    output logic                           o_valid,
    output logic [lcs_pkg::PIX_W-1:0]      o_out_pixel
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                       r_state;
    logic [lcs_pkg::STEP_W-1:0]   r_step;
    logic [lcs_pkg::NUM_W-1:0]    r_rem;
    logic [lcs_pkg::DSH_W-1:0]    r_dsh;
    logic [lcs_pkg::PIX_W-1:0]    r_quo;
    logic                         r_out_valid;
    logic [lcs_pkg::PIX_W-1:0]    r_out_pixel;

    logic [lcs_pkg::PIX_W-1:0]    p;
    logic [lcs_pkg::PIX_W-1:0]    lo;
    logic [lcs_pkg::PIX_W-1:0]    hi;
    logic [lcs_pkg::PIX_W-1:0]    diff;
    logic [lcs_pkg::PIX_W-1:0]    delta;
    logic [lcs_pkg::NUM_W-1:0]    n_num;
    logic [lcs_pkg::DSH_W-1:0]    n_dsh;
    logic                         bypass;
    logic [lcs_pkg::PIX_W-1:0]    bypass_val;
    logic [lcs_pkg::NUM_W-1:0]    dsh_ext;
    logic                         fits;
    logic                         out_free;

    assign p     = i_status.head.pixel;
    assign lo    = i_status.head.lo;
    assign hi    = i_status.head.hi;
    assign diff  = hi - lo;
    assign delta = p - lo;

    // 2 * (p - lo) * 255 + diff, with the multiply by 255 as a shift and subtract.
    assign n_num = {({delta, lcs_pkg::PIX_W'(0)} - {8'd0, delta}), 1'b0}
                   + lcs_pkg::NUM_W'(diff);
    // Divisor 2 * diff, aligned to quotient bit 7.
    assign n_dsh = {diff, 1'b0, 7'd0};

    // Empty or flat range passes through; at or outside the range saturates.
    always_comb begin
        bypass     = 1'b1;
        bypass_val = p;
        if (lo >= hi) begin
            bypass_val = p;
        end else if (p <= lo) begin
            bypass_val = lcs_pkg::PIX_MIN;
        end else if (p >= hi) begin
            bypass_val = lcs_pkg::PIX_MAX;
        end else begin
            bypass = 1'b0;
        end
    end

    assign dsh_ext  = lcs_pkg::NUM_W'(r_dsh);
    assign fits     = (r_rem >= dsh_ext);
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_status.empty;

    assign o_valid     = r_out_valid;
    assign o_out_pixel = r_out_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the done state the result register is handled below.
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_status.empty) begin
                        r_step <= '0;
                        r_rem  <= n_num;
                        r_dsh  <= n_dsh;
                        r_quo  <= bypass_val;
                        r_state <= bypass ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    if (fits) begin
                        r_rem <= r_rem - dsh_ext;
                    end
                    r_quo  <= {r_quo[lcs_pkg::PIX_W-2:0], fits};
                    r_dsh  <= r_dsh >> 1;
                    r_step <= r_step + 1'b1;
                    if (r_step == lcs_pkg::LAST_STEP) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pixel <= r_quo;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_div_has_divisor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == '0) |-> (r_dsh != '0))
        else $error("division started with a zero range");

    a_div_ends_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == lcs_pkg::LAST_STEP) |=> (r_state == S_DONE))
        else $error("division did not finish after eight steps");

    a_load_only_from_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid)) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the done state");

endmodule

`default_nettype wire
